/* sv/bsc_pkg.sv */
// ----------------------------------------------------------------------------
// Barometric compensation package
// Widths, register indexes, compensation constants and shared helpers.
// ----------------------------------------------------------------------------
package bsc_pkg;

   localparam int UT_W    = 16;
   localparam int UP_W    = 19;
   localparam int PRESS_W = 17;
   localparam int TEMP_W  = 16;
   localparam int CSR_W   = 32;
   localparam int CSR_IW  = 3;
   localparam int DIV_W   = 32;

   typedef enum logic [CSR_IW-1:0] {
      CSR_OSS     = 3'd0,
      CSR_AC1_AC2 = 3'd1,
      CSR_AC3_AC4 = 3'd2,
      CSR_AC5_AC6 = 3'd3,
      CSR_B1_B2   = 3'd4,
      CSR_MC_MD   = 3'd5
   } csr_idx_type;

   localparam logic [31:0] T_OFFSET  = 32'd4000;
   localparam logic [31:0] P_ROUND   = 32'd32768;
   localparam logic [31:0] P_SCALE   = 32'd50000;
   localparam logic [31:0] P_K1      = 32'd3038;
   localparam logic [31:0] P_K2      = 32'hFFFF_E343;
   localparam logic [31:0] P_K3      = 32'd3791;
   localparam logic [31:0] T_ROUND   = 32'd8;
   localparam logic [PRESS_W-1:0] PRESS_MAX = '1;

   function automatic logic [31:0] asr(input logic [31:0] x, input int unsigned n);
      asr = 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sx16(input logic [15:0] h);
      sx16 = {{16{h[15]}}, h};
   endfunction

endpackage

/* sv/bsc_req_if.sv */
// ----------------------------------------------------------------------------
// Request channel
// Raw temperature and pressure pair with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsc_req_if;
   import bsc_pkg::*;

   logic            valid;
   logic            ready;
   logic [UT_W-1:0] raw_temperature;
   logic [UP_W-1:0] raw_pressure;

   modport source (output valid, raw_temperature, raw_pressure, input ready);
   modport sink   (input valid, raw_temperature, raw_pressure, output ready);
endinterface

/* sv/bsc_rsp_if.sv */
// ----------------------------------------------------------------------------
// Response channel
// Compensated pressure, temperature and status with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bsc_rsp_if;
   import bsc_pkg::*;

   logic               valid;
   logic               ready;
   logic [PRESS_W-1:0] pressure_pa;
   logic [TEMP_W-1:0]  temperature_tenths;
   logic               status;

   modport source (output valid, pressure_pa, temperature_tenths, status, input ready);
   modport sink   (input valid, pressure_pa, temperature_tenths, status, output ready);
endinterface

/* sv/barometric_sensor_compensation_core.sv */
// ----------------------------------------------------------------------------
// Barometric sensor compensation core
// Integer temperature and pressure compensation from calibration words.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                         | handshake
//  req     | in  | raw_temperature[16], raw_pressure[19]           | valid/ready
//  rsp     | out | pressure_pa[17], temperature_tenths[16], status | valid/ready
//  csr     | in  | csr_index[3], csr_wdata[32]                     | csr_we
//
//  One request per cycle while rsp is not held; the pipe is the two
//  32-stage dividers plus 14 arithmetic stages.
//  Reset is synchronous; it clears valid bits and the calibration registers.
//  When rsp is held, every stage holds and req.ready drops.
// ----------------------------------------------------------------------------
module barometric_sensor_compensation_core (
   input  logic                       clock,
   input  logic                       reset,
   bsc_req_if.sink                    req,
   bsc_rsp_if.source                  rsp,
   input  logic                       csr_we,
   input  logic [bsc_pkg::CSR_IW-1:0] csr_index,
   input  logic [bsc_pkg::CSR_W-1:0]  csr_wdata
);
   import bsc_pkg::*;

   logic [1:0]  oss_ff;
   logic [31:0] ac12_ff, ac34_ff, ac56_ff, b12_ff, mcmd_ff;
   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   logic        adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         oss_ff  <= '0;
         ac12_ff <= '0;
         ac34_ff <= '0;
         ac56_ff <= '0;
         b12_ff  <= '0;
         mcmd_ff <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_OSS:     oss_ff  <= csr_wdata[1:0];
            CSR_AC1_AC2: ac12_ff <= csr_wdata;
            CSR_AC3_AC4: ac34_ff <= csr_wdata;
            CSR_AC5_AC6: ac56_ff <= csr_wdata;
            CSR_B1_B2:   b12_ff  <= csr_wdata;
            CSR_MC_MD:   mcmd_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign ac1 = sx16(ac12_ff[31:16]);
   assign ac2 = sx16(ac12_ff[15:0]);
   assign ac3 = sx16(ac34_ff[31:16]);
   assign ac4 = {16'd0, ac34_ff[15:0]};
   assign ac5 = {16'd0, ac56_ff[31:16]};
   assign ac6 = {16'd0, ac56_ff[15:0]};
   assign b1  = sx16(b12_ff[31:16]);
   assign b2  = sx16(b12_ff[15:0]);
   assign mc  = sx16(mcmd_ff[31:16]);
   assign md  = sx16(mcmd_ff[15:0]);

   // advance the whole pipe unless the output is held
   assign adv       = ~rsp.valid | rsp.ready;
   assign req.ready = adv;

   // stage registers
   logic              v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff, v8_ff, v9_ff, v10_ff;
   logic              v11_ff, v12_ff, v13_ff, v14_ff;
   logic [UT_W-1:0]   ut1_ff;
   logic [UP_W-1:0]   up1_ff, up2_ff, up3_ff, up4_ff, up5_ff, up6_ff, up7_ff, up8_ff;
   logic [31:0]       x1_2_ff, x1_3_ff;
   logic [31:0]       num3_ff, den3_ff;
   logic              neg3_ff, err3_ff;
   logic              err4_ff, err5_ff, err6_ff, err7_ff, err8_ff, err9_ff, err10_ff;
   logic              err11_ff, err12_ff, err13_ff;
   logic [31:0]       b5_4_ff, b6_5_ff;
   logic [TEMP_W-1:0] ts5_ff, ts6_ff, ts7_ff, ts8_ff, ts9_ff, ts10_ff, ts11_ff, ts12_ff;
   logic [TEMP_W-1:0] ts13_ff;
   logic [31:0]       sq6_ff, x2a6_ff, x1b6_ff;
   logic [31:0]       x1a7_ff, x2b7_ff, x2a7_ff, x1b7_ff;
   logic [31:0]       b3_8_ff, x3b8_ff;
   logic [31:0]       b4_9_ff, diff9_ff;
   logic [31:0]       b7_10_ff, b4_10_ff;
   logic [31:0]       p11_ff, p12_ff, p13_ff;
   logic [31:0]       x1_12_ff, x2_12_ff, x1_13_ff, x2_13_ff;
   logic [PRESS_W-1:0] press_ff;
   logic [TEMP_W-1:0]  temp_ff;
   logic               stat_ff;

   // combinational terms
   logic [31:0] s2_x1, s3_d, s3_a;
   logic [31:0] s4_x2, s5_t, s5_ts_w;
   logic [TEMP_W-1:0] s5_ts;
   logic [31:0] s8_b3, s8_x3b, s9_b4, s10_b7;
   logic [31:0] s12_t, s14_p;
   logic [PRESS_W-1:0] s14_press;
   logic        d1_vld, d2_vld;
   logic [31:0] d1_quo, d2_quo;
   logic [UP_W+1:0] d1_side;
   logic [TEMP_W+1:0] d2_side;
   logic [31:0] d2_num;

   assign s2_x1 = asr(32'((32'(ut1_ff) - ac6) * ac5), 15);
   assign s3_d  = x1_2_ff + md;
   assign s3_a  = mc << 11;

   bsc_div_pipe #(.W(DIV_W), .SW(UP_W + 2)) u_div_temp (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (v3_ff),
      .in_num   (num3_ff),
      .in_den   (den3_ff),
      .in_side  ({neg3_ff, err3_ff, up3_ff}),
      .out_valid(d1_vld),
      .out_quo  (d1_quo),
      .out_side (d1_side)
   );

   // x1 travels beside the divider
   logic [31:0] x1_dl_ff [1:DIV_W];
   for (genvar k = 1; k <= DIV_W; k++) begin : g_x1dl
      always_ff @(posedge clock) begin
         if (adv) begin
            x1_dl_ff[k] <= (k == 1) ? x1_3_ff : x1_dl_ff[(k > 1) ? k - 1 : 1];
         end
      end
   end

   assign s4_x2   = d1_side[UP_W+1] ? (32'd0 - d1_quo) : d1_quo;
   assign s5_t    = asr(b5_4_ff + T_ROUND, 4);
   assign s5_ts_w = s5_t;
   always_comb begin
      if ($signed(s5_ts_w) < -32'sd32768) begin
         s5_ts = {1'b1, {(TEMP_W-1){1'b0}}};
      end else if ($signed(s5_ts_w) > 32'sd32767) begin
         s5_ts = {1'b0, {(TEMP_W-1){1'b1}}};
      end else begin
         s5_ts = s5_ts_w[TEMP_W-1:0];
      end
   end

   assign s8_b3  = asr(32'((((ac1 << 2) + x1a7_ff + x2a7_ff) << oss_ff) + 32'd2), 2);
   assign s8_x3b = asr(x1b7_ff + x2b7_ff + 32'd2, 2);
   assign s9_b4  = 32'(ac4 * (x3b8_ff + P_ROUND)) >> 15;
   assign s10_b7 = 32'(diff9_ff * (P_SCALE >> oss_ff));
   assign d2_num = b7_10_ff[31] ? b7_10_ff : (b7_10_ff << 1);

   bsc_div_pipe #(.W(DIV_W), .SW(TEMP_W + 2)) u_div_press (
      .clock    (clock),
      .reset    (reset),
      .en       (adv),
      .in_valid (v10_ff),
      .in_num   (d2_num),
      .in_den   (b4_10_ff),
      .in_side  ({b7_10_ff[31], err10_ff | (b4_10_ff == 32'd0), ts10_ff}),
      .out_valid(d2_vld),
      .out_quo  (d2_quo),
      .out_side (d2_side)
   );

   assign s12_t = asr(p11_ff, 8);
   assign s14_p = p13_ff + asr(x1_13_ff + x2_13_ff + P_K3, 4);
   always_comb begin
      if (s14_p[31]) begin
         s14_press = '0;
      end else if (s14_p > 32'(PRESS_MAX)) begin
         s14_press = PRESS_MAX;
      end else begin
         s14_press = s14_p[PRESS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
         v13_ff <= 1'b0;
         v14_ff <= 1'b0;
      end else if (adv) begin
         v1_ff  <= req.valid;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= d1_vld;
         v5_ff  <= v4_ff;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= d2_vld;
         v12_ff <= v11_ff;
         v13_ff <= v12_ff;
         v14_ff <= v13_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ut1_ff   <= req.raw_temperature;
         up1_ff   <= req.raw_pressure;
         x1_2_ff  <= s2_x1;
         up2_ff   <= up1_ff;
         num3_ff  <= s3_a[31] ? (32'd0 - s3_a) : s3_a;
         den3_ff  <= s3_d[31] ? (32'd0 - s3_d) : s3_d;
         neg3_ff  <= s3_a[31] ^ s3_d[31];
         err3_ff  <= (s3_d == 32'd0);
         x1_3_ff  <= x1_2_ff;
         up3_ff   <= up2_ff;
         b5_4_ff  <= x1_dl_ff[DIV_W] + s4_x2;
         err4_ff  <= d1_side[UP_W];
         up4_ff   <= d1_side[UP_W-1:0];
         ts5_ff   <= s5_ts;
         b6_5_ff  <= b5_4_ff - T_OFFSET;
         err5_ff  <= err4_ff;
         up5_ff   <= up4_ff;
         sq6_ff   <= asr(32'(b6_5_ff * b6_5_ff), 12);
         x2a6_ff  <= asr(32'(ac2 * b6_5_ff), 11);
         x1b6_ff  <= asr(32'(ac3 * b6_5_ff), 13);
         ts6_ff   <= ts5_ff;
         err6_ff  <= err5_ff;
         up6_ff   <= up5_ff;
         x1a7_ff  <= asr(32'(b2 * sq6_ff), 11);
         x2b7_ff  <= asr(32'(b1 * sq6_ff), 16);
         x2a7_ff  <= x2a6_ff;
         x1b7_ff  <= x1b6_ff;
         ts7_ff   <= ts6_ff;
         err7_ff  <= err6_ff;
         up7_ff   <= up6_ff;
         b3_8_ff  <= s8_b3;
         x3b8_ff  <= s8_x3b;
         ts8_ff   <= ts7_ff;
         err8_ff  <= err7_ff;
         up8_ff   <= up7_ff;
         b4_9_ff  <= s9_b4;
         diff9_ff <= 32'(up8_ff) - b3_8_ff;
         ts9_ff   <= ts8_ff;
         err9_ff  <= err8_ff;
         b7_10_ff <= s10_b7;
         b4_10_ff <= b4_9_ff;
         ts10_ff  <= ts9_ff;
         err10_ff <= err9_ff;
         p11_ff   <= d2_side[TEMP_W+1] ? (d2_quo << 1) : d2_quo;
         err11_ff <= d2_side[TEMP_W];
         ts11_ff  <= d2_side[TEMP_W-1:0];
         x1_12_ff <= 32'(s12_t * s12_t);
         x2_12_ff <= asr(32'(P_K2 * p11_ff), 16);
         p12_ff   <= p11_ff;
         err12_ff <= err11_ff;
         ts12_ff  <= ts11_ff;
         x1_13_ff <= asr(32'(x1_12_ff * P_K1), 16);
         x2_13_ff <= x2_12_ff;
         p13_ff   <= p12_ff;
         err13_ff <= err12_ff;
         ts13_ff  <= ts12_ff;
         press_ff <= err13_ff ? '0 : s14_press;
         temp_ff  <= err13_ff ? '0 : ts13_ff;
         stat_ff  <= err13_ff;
      end
   end

   assign rsp.valid              = v14_ff;
   assign rsp.pressure_pa        = press_ff;
   assign rsp.temperature_tenths = temp_ff;
   assign rsp.status             = stat_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.status |-> rsp.pressure_pa == '0 && rsp.temperature_tenths == '0)
      else $error("error response carries nonzero data");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req.ready == (!rsp.valid || rsp.ready))
      else $error("request ready does not follow output stall");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v13_ff) && $stable(p13_ff))
      else $error("pipeline moved during stall");
endmodule

/* sv/bsc_div_pipe.sv */
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, with sideband.
// ----------------------------------------------------------------------------
module bsc_div_pipe #(
   parameter int W  = 32,
   parameter int SW = 1
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          en,
   input  logic          in_valid,
   input  logic [W-1:0]  in_num,
   input  logic [W-1:0]  in_den,
   input  logic [SW-1:0] in_side,
   output logic          out_valid,
   output logic [W-1:0]  out_quo,
   output logic [SW-1:0] out_side
);
   logic          vld_ff  [1:W];
   logic [W-1:0]  rem_ff  [1:W];
   logic [W-1:0]  num_ff  [1:W];
   logic [W-1:0]  den_ff  [1:W];
   logic [SW-1:0] side_ff [1:W];

   for (genvar k = 0; k < W; k++) begin : g_stage
      logic          src_vld;
      logic [W-1:0]  src_rem;
      logic [W-1:0]  src_num;
      logic [W-1:0]  src_den;
      logic [SW-1:0] src_side;
      logic [W:0]    trial;
      logic          ge;

      if (k == 0) begin : g_first
         assign src_vld  = in_valid;
         assign src_rem  = '0;
         assign src_num  = in_num;
         assign src_den  = in_den;
         assign src_side = in_side;
      end else begin : g_next
         assign src_vld  = vld_ff[k];
         assign src_rem  = rem_ff[k];
         assign src_num  = num_ff[k];
         assign src_den  = den_ff[k];
         assign src_side = side_ff[k];
      end

      assign trial = {src_rem, src_num[W-1]} - {1'b0, src_den};
      assign ge    = ~trial[W];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k+1]  <= ge ? trial[W-1:0] : {src_rem[W-2:0], src_num[W-1]};
            num_ff[k+1]  <= {src_num[W-2:0], ge};
            den_ff[k+1]  <= src_den;
            side_ff[k+1] <= src_side;
         end
      end
   end

   assign out_valid = vld_ff[W];
   assign out_quo   = num_ff[W];
   assign out_side  = side_ff[W];
endmodule

/* tb/tb_barometric_sensor_compensation_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Barometric compensation core testbench
// Drives raw reading pairs through the core under several calibration sets and
// throttling phases, predicts every response in integer arithmetic and checks
// pressure, temperature and status in request order.
// ----------------------------------------------------------------------------
module tb_barometric_sensor_compensation_core;
   import bsc_pkg::*;

   typedef struct packed {
      logic [PRESS_W-1:0] pressure_pa;
      logic [TEMP_W-1:0]  temperature_tenths;
      logic               status;
   } comp_result_type;

   typedef struct {
      logic [UT_W-1:0] ut;
      logic [UP_W-1:0] up;
      bit              typed;
      comp_result_type result;
   } stim_row_type;

   localparam int LATENCY  = 78;
   localparam int HOLD_LEN = 300;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_IW-1:0] csr_index;
   logic [CSR_W-1:0]  csr_wdata;

   bsc_req_if req ();
   bsc_rsp_if rsp ();

   barometric_sensor_compensation_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [1:0]  oss_q;
   logic [31:0] cal_q [1:5];

   comp_result_type pending_results [$];
   int errors;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_req;
   int hold_seen;
   int hold_left;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic logic [31:0] sra(logic [31:0] x, int n);
      return 32'($signed(x) >>> n);
   endfunction

   function automatic logic [31:0] sext(logic [15:0] h);
      return {{16{h[15]}}, h};
   endfunction

   function automatic logic [31:0] div_signed(logic [31:0] a, logic [31:0] b);
      logic [31:0] ma, mb, q;
      ma = a[31] ? -a : a;
      mb = b[31] ? -b : b;
      q = ma / mb;
      return (a[31] != b[31]) ? -q : q;
   endfunction

   function automatic comp_result_type compensate(logic [UT_W-1:0] ut_in,
                                                  logic [UP_W-1:0] up_in);
      logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
      logic [31:0] x1, x2, x3, d, b5, b6, b3, b4, b7, p, sq, ts, ut, up;
      comp_result_type r;
      ac1 = sext(cal_q[1][31:16]);
      ac2 = sext(cal_q[1][15:0]);
      ac3 = sext(cal_q[2][31:16]);
      ac4 = {16'd0, cal_q[2][15:0]};
      ac5 = {16'd0, cal_q[3][31:16]};
      ac6 = {16'd0, cal_q[3][15:0]};
      b1  = sext(cal_q[4][31:16]);
      b2  = sext(cal_q[4][15:0]);
      mc  = sext(cal_q[5][31:16]);
      md  = sext(cal_q[5][15:0]);
      ut  = {16'd0, ut_in};
      up  = {13'd0, up_in};
      r = '{pressure_pa: '0, temperature_tenths: '0, status: 1'b1};
      x1 = sra((ut - ac6) * ac5, 15);
      d = x1 + md;
      if (d == 0) return r;
      x2 = div_signed(mc << 11, d);
      b5 = x1 + x2;
      ts = sra(b5 + 32'd8, 4);
      b6 = b5 - 32'd4000;
      sq = sra(b6 * b6, 12);
      x1 = sra(b2 * sq, 11);
      x2 = sra(ac2 * b6, 11);
      x3 = x1 + x2;
      b3 = sra((((ac1 << 2) + x3) << oss_q) + 32'd2, 2);
      x1 = sra(ac3 * b6, 13);
      x2 = sra(b1 * sq, 16);
      x3 = sra(x1 + x2 + 32'd2, 2);
      b4 = (ac4 * (x3 + 32'd32768)) >> 15;
      if (b4 == 0) return r;
      b7 = (up - b3) * (32'd50000 >> oss_q);
      if (!b7[31]) p = (b7 << 1) / b4;
      else p = (b7 / b4) << 1;
      x1 = sra(p, 8) * sra(p, 8);
      x1 = sra(x1 * 32'd3038, 16);
      x2 = sra(32'hFFFF_E343 * p, 16);
      p = p + sra(x1 + x2 + 32'd3791, 4);
      if (p[31]) r.pressure_pa = '0;
      else if (p > 32'd131071) r.pressure_pa = PRESS_MAX;
      else r.pressure_pa = p[PRESS_W-1:0];
      if ($signed(ts) < -32768) r.temperature_tenths = 16'h8000;
      else if ($signed(ts) > 32767) r.temperature_tenths = 16'h7FFF;
      else r.temperature_tenths = ts[15:0];
      r.status = 1'b0;
      return r;
   endfunction

   task automatic write_csr(csr_idx_type idx, logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_OSS) oss_q = value[1:0];
      else if (idx <= CSR_MC_MD) cal_q[idx] = value;
   endtask

   task automatic write_raw_index(logic [CSR_IW-1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic load_calibration(logic [1:0] oss, logic [31:0] w1, logic [31:0] w2,
                                   logic [31:0] w3, logic [31:0] w4, logic [31:0] w5);
      write_csr(CSR_OSS, {30'd0, oss});
      write_csr(CSR_AC1_AC2, w1);
      write_csr(CSR_AC3_AC4, w2);
      write_csr(CSR_AC5_AC6, w3);
      write_csr(CSR_B1_B2, w4);
      write_csr(CSR_MC_MD, w5);
   endtask

   task automatic send_request(logic [UT_W-1:0] ut, logic [UP_W-1:0] up,
                               bit typed, comp_result_type typed_result);
      comp_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      predicted = compensate(ut, up);
      if (typed && predicted != typed_result) begin
         $display("%0t table row disagrees: expected %h predicted %h", $time,
                  typed_result, predicted);
         errors++;
      end
      pending_results.push_back(typed ? typed_result : predicted);
      req.valid <= 1'b1;
      req.raw_temperature <= ut;
      req.raw_pressure <= up;
      do @(posedge clock); while (!req.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
   endtask

   task automatic random_burst(int count, int idle_pct, int stall_pct);
      logic [UT_W-1:0] ut;
      logic [UP_W-1:0] up;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      repeat (count) begin
         case ($urandom_range(3))
            0: begin
               ut = 16'($urandom);
               up = 19'($urandom);
            end
            default: begin
               ut = 16'($urandom_range(20000, 34000));
               up = 19'($urandom_range(20000, 100000) << oss_q);
            end
         endcase
         send_request(ut, up, 1'b0, '0);
      end
   endtask

   always @(posedge clock) begin
      comp_result_type got, want;
      if (!reset && rsp.valid && rsp.ready) begin
         got = '{rsp.pressure_pa, rsp.temperature_tenths, rsp.status};
         if (pending_results.size() == 0) begin
            $display("%0t unexpected response: actual %h", $time, got);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (got.pressure_pa !== want.pressure_pa)
               begin
               $display("%0t pressure_pa: expected %0d actual %0d", $time,
                        want.pressure_pa, got.pressure_pa);
               errors++;
            end
            if (got.temperature_tenths !== want.temperature_tenths) begin
               $display("%0t temperature_tenths: expected %0d actual %0d", $time,
                        $signed(want.temperature_tenths), $signed(got.temperature_tenths));
               errors++;
            end
            if (got.status !== want.status) begin
               $display("%0t status: expected %0d actual %0d", $time,
                        want.status, got.status);
               errors++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen = hold_req;
         hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
         rsp.ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   initial begin
      #50_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      stim_row_type rows [$];
      errors = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_req = 0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.raw_temperature = '0;
      req.raw_pressure = '0;
      oss_q = '0;
      for (int i = 1; i <= 5; i++) cal_q[i] = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // after reset all calibration is zero: temperature divisor is zero
      rows.push_back('{16'h0000, 19'h00000, 1'b1, '{17'd0, 16'd0, 1'b1}});
      rows.push_back('{16'hFFFF, 19'h7FFFF, 1'b1, '{17'd0, 16'd0, 1'b1}});
      foreach (rows[i]) send_request(rows[i].ut, rows[i].up, rows[i].typed, rows[i].result);
      drain();

      // datasheet example calibration
      load_calibration(2'd0, {16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
                       {16'd32757, 16'd23153}, {16'd6190, 16'd4},
                       {-16'sd8711, 16'd2868});
      rows = {};
      rows.push_back('{16'd27898, 19'd23843, 1'b0, '0});
      rows.push_back('{16'h0000, 19'h00000, 1'b0, '0});
      rows.push_back('{16'hFFFF, 19'h7FFFF, 1'b0, '0});
      rows.push_back('{16'h0000, 19'h7FFFF, 1'b0, '0});
      rows.push_back('{16'hFFFF, 19'h00000, 1'b0, '0});
      rows.push_back('{16'h8000, 19'h40000, 1'b0, '0});
      rows.push_back('{16'h7FFF, 19'h3FFFF, 1'b0, '0});
      rows.push_back('{16'h5555, 19'h2AAAA, 1'b0, '0});
      rows.push_back('{16'hAAAA, 19'h55555, 1'b0, '0});
      foreach (rows[i]) send_request(rows[i].ut, rows[i].up, rows[i].typed, rows[i].result);
      drain();

      // write beyond the calibration registers: ignored
      write_raw_index(3'd6, 32'hFFFF_FFFF);
      write_raw_index(3'd7, 32'h1234_5678);
      // zero pressure divisor: AC4 is zero
      write_csr(CSR_AC3_AC4, {-16'sd14383, 16'd0});
      rows = {};
      rows.push_back('{16'd27898, 19'd23843, 1'b1, '{17'd0, 16'd0, 1'b1}});
      foreach (rows[i]) send_request(rows[i].ut, rows[i].up, rows[i].typed, rows[i].result);
      drain();

      // MC extreme with MD of -1 drives the signed divide edge; extreme temps
      load_calibration(2'd3, 32'h7FFF_8000, 32'h8000_FFFF, 32'hFFFF_0000,
                       32'h7FFF_8000, 32'h8000_FFFF);
      rows = {};
      rows.push_back('{16'h0000, 19'h00000, 1'b0, '0});
      rows.push_back('{16'hFFFF, 19'h7FFFF, 1'b0, '0});
      rows.push_back('{16'h0001, 19'h00001, 1'b0, '0});
      rows.push_back('{16'hFFFE, 19'h7FFFE, 1'b0, '0});
      foreach (rows[i]) send_request(rows[i].ut, rows[i].up, rows[i].typed, rows[i].result);
      drain();

      load_calibration(2'd0, {16'd408, -16'sd72}, {-16'sd14383, 16'd32741},
                       {16'd32757, 16'd23153}, {16'd6190, 16'd4},
                       {-16'sd8711, 16'd2868});
      random_burst(60, 0, 0);
      random_burst(60, 77, 0);
      random_burst(60, 0, 77);
      random_burst(60, 14, 14);

      // hold the response side while requests keep coming
      send_idle_pct = 0;
      recv_stall_pct = 0;
      hold_req++;
      random_burst(120, 0, 0);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         load_calibration(2'(phase), $urandom, $urandom, $urandom, $urandom, $urandom);
         random_burst(20, 14, 14);
         drain();
         load_calibration(2'(phase), {16'($urandom_range(300, 9000)), 16'($urandom)},
                          {16'($urandom), 16'($urandom_range(20000, 65535))},
                          {16'($urandom_range(15000, 35000)), 16'($urandom_range(15000, 30000))},
                          $urandom, {16'($urandom), 16'($urandom_range(1000, 5000))});
         random_burst(20, 77, 77);
         drain();
      end

      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
